FILE: sv/spf_pkg.sv
// Package for the spin projection filter: item structs, op codes, states.
// No dependencies.
package spf_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef enum logic [1:0] {
      OP_DIAG   = 2'd0,
      OP_TRIPLE = 2'd1,
      OP_VECTOR = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_DIM    = 2'd0,
      CSR_COUNT  = 2'd1,
      CSR_SPINS  = 2'd2,
      CSR_DESIRE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  slot;
      logic [5:0]  row_index;
      logic [5:0]  col_index;
      logic signed [31:0] value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_row;
      logic signed [31:0] out_value;
      logic        out_last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_SPIN,
      ST_DIAG_RD,
      ST_DIAG_WR,
      ST_TRI_RD,
      ST_TRI_OLD,
      ST_TRI_ROW,
      ST_TRI_COL,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qtrunc(input logic signed [63:0] p);
      logic signed [47:0] q;
      q = p[63:16];
      if (q > 48'sd2147483647) return 32'sh7fffffff;
      if (q < -48'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

endpackage

FILE: sv/spf_queue.sv
// Short item queue between the front and back parts.
// Depends on spf_pkg.
module spf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spf_pkg::req_type  push_item,
   output logic              full,
   input  logic              pop,
   output spf_pkg::req_type  pop_item,
   output logic              not_empty
);
   import spf_pkg::*;
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type           mem_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = mem_ff[rd_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count");
endmodule

FILE: sv/spf_engine.sv
// Back part: stores and the sequenced filter pass.
// Depends on spf_pkg.
module spf_engine #(
   parameter int unsigned MAX_DIM     = 64,
   parameter int unsigned MAX_OFFDIAG = 256,
   parameter int unsigned SPIN_LIMIT  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  spf_pkg::req_type  item,
   output logic              item_pop,
   input  logic [6:0]        dim_reg,
   input  logic [8:0]        count_reg,
   input  logic [4:0]        spins_reg,
   input  logic [3:0]        desire_reg,
   output logic              rsp_strobe,
   output spf_pkg::rsp_type  rsp_item
);
   import spf_pkg::*;
   localparam int unsigned DW = $clog2(MAX_DIM);
   localparam int unsigned TW = (MAX_OFFDIAG > 1) ? $clog2(MAX_OFFDIAG) : 1;
   localparam int unsigned SW = $clog2(SPIN_LIMIT) + 1;

   logic signed [31:0] diag_mem   [MAX_DIM];
   logic signed [31:0] vec_mem    [MAX_DIM];
   logic signed [31:0] scr_mem    [MAX_DIM];
   logic signed [31:0] old_mem    [MAX_DIM];
   logic [43:0]        tri_mem    [MAX_OFFDIAG];

   state_type st_ff, st_in;
   logic [DW:0]  n_ff, n_in, i_ff, i_in;
   logic [TW:0]  nt_ff, nt_in, k_ff, k_in;
   logic [SW-1:0] s_ff, s_in, ns_ff, ns_in;

   logic signed [31:0] dv_ff, ov_ff, sv_ff, sc_ff, oc_ff, or_ff, vv_ff;
   logic [43:0]        tr_ff;
   logic signed [31:0] coef_val;

   logic [DW-1:0] i_ix;
   logic [5:0] t_row, t_col;
   logic signed [31:0] t_val;
   logic t_ok;
   logic [31:0] shift_val;

   assign i_ix  = i_ff[DW-1:0];
   assign t_row = tr_ff[43:38];
   assign t_col = tr_ff[37:32];
   assign t_val = tr_ff[31:0];
   assign t_ok  = (32'(t_row) < 32'(n_ff)) && (32'(t_col) < 32'(n_ff))
                  && (int'(t_row) < MAX_DIM) && (int'(t_col) < MAX_DIM);
   assign shift_val = 32'(s_ff) * 32'(s_ff + 2'd2) * 32'd16384;

   logic go;
   assign go = item_valid && (st_ff == ST_IDLE);

   always_comb begin
      st_in = st_ff;
      n_in = n_ff; i_in = i_ff; nt_in = nt_ff; k_in = k_ff;
      s_in = s_ff; ns_in = ns_ff;
      case (st_ff)
         ST_IDLE: begin
            if (go && item.op == OP_VECTOR && item.last) begin
               n_in  = (32'(dim_reg) > MAX_DIM) ? (DW+1)'(MAX_DIM) : (DW+1)'(dim_reg);
               nt_in = (32'(count_reg) > MAX_OFFDIAG) ? (TW+1)'(MAX_OFFDIAG)
                       : (TW+1)'(count_reg);
               ns_in = (32'(spins_reg) > SPIN_LIMIT) ? SW'(SPIN_LIMIT) : SW'(spins_reg);
               i_in  = '0;
               st_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (i_ff == n_ff) begin
               s_in = '0;
               st_in = ST_SPIN;
            end else i_in = i_ff + 1'b1;
         end
         ST_SPIN: begin
            i_in = '0;
            if (s_ff == ns_ff) st_in = ST_EMIT_RD;
            else if (32'(s_ff) == 32'(desire_reg)) s_in = s_ff + 1'b1;
            else st_in = ST_DIAG_RD;
         end
         ST_DIAG_RD: begin
            if (i_ff == n_ff) begin
               k_in = '0;
               st_in = ST_TRI_RD;
            end else st_in = ST_DIAG_WR;
         end
         ST_DIAG_WR: begin
            i_in = i_ff + 1'b1;
            st_in = ST_DIAG_RD;
         end
         ST_TRI_RD: begin
            if (k_ff == nt_ff) begin
               s_in = s_ff + 1'b1;
               st_in = ST_SPIN;
            end else st_in = ST_TRI_OLD;
         end
         ST_TRI_OLD: begin
            if (t_ok) st_in = ST_TRI_ROW;
            else begin
               k_in = k_ff + 1'b1;
               st_in = ST_TRI_RD;
            end
         end
         ST_TRI_ROW: st_in = ST_TRI_COL;
         ST_TRI_COL: begin
            k_in = k_ff + 1'b1;
            st_in = ST_TRI_RD;
         end
         ST_EMIT_RD: begin
            if (i_ff == n_ff) st_in = ST_IDLE;
            else st_in = ST_EMIT;
         end
         ST_EMIT: begin
            i_in = i_ff + 1'b1;
            st_in = ST_EMIT_RD;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_pop   = go;
      rsp_strobe = (st_ff == ST_EMIT);
      rsp_item.out_row   = 6'(i_ff);
      rsp_item.out_value = sv_ff;
      rsp_item.out_last  = (i_ff + 1'b1 == n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         n_ff <= '0; i_ff <= '0; nt_ff <= '0; k_ff <= '0;
         s_ff <= '0; ns_ff <= '0;
      end else begin
         st_ff <= st_in;
         n_ff <= n_in; i_ff <= i_in; nt_ff <= nt_in; k_ff <= k_in;
         s_ff <= s_in; ns_ff <= ns_in;
      end
   end

   // Loads
   always_ff @(posedge clock) begin
      if (go) begin
         case (item.op)
            OP_DIAG:
               if (32'(item.slot) < MAX_DIM) diag_mem[DW'(item.slot)] <= item.value;
            OP_TRIPLE:
               if (32'(item.slot) < MAX_OFFDIAG)
                  tri_mem[TW'(item.slot)] <= {item.row_index, item.col_index, item.value};
            OP_VECTOR:
               if (32'(item.slot) < MAX_DIM) vec_mem[DW'(item.slot)] <= item.value;
            default: ;
         endcase
      end
   end

   // Datapath: registered memory reads
   always_ff @(posedge clock) begin
      case (st_ff)
         ST_COPY: if (i_ff != n_ff) vv_ff <= vec_mem[i_ix];
         ST_DIAG_RD: if (i_ff != n_ff) begin
            dv_ff <= diag_mem[i_ix];
            ov_ff <= scr_mem[i_ix];
         end
         ST_TRI_RD: tr_ff <= tri_mem[k_ff[TW-1:0]];
         ST_TRI_OLD: begin
            oc_ff <= old_mem[DW'(t_col)];
            or_ff <= old_mem[DW'(t_row)];
         end
         ST_TRI_ROW: begin
            sv_ff <= scr_mem[DW'(t_row)];
            sc_ff <= scr_mem[DW'(t_col)];
         end
         ST_EMIT_RD: if (i_ff != n_ff) sv_ff <= scr_mem[i_ix];
         default: ;
      endcase
   end

   logic copy_wr_ff;
   logic [DW-1:0] copy_ix_ff;
   always_ff @(posedge clock) begin
      if (reset) copy_wr_ff <= 1'b0;
      else copy_wr_ff <= (st_ff == ST_COPY) && (i_ff != n_ff);
      copy_ix_ff <= i_ix;
   end

   logic signed [31:0] diag_res, row_res, col_res, scr_col;
   assign coef_val = sat32(34'(dv_ff) - 34'(signed'({1'b0, shift_val})));
   assign diag_res = qtrunc(64'(coef_val) * 64'(ov_ff));
   assign row_res  = sat32(34'(sv_ff) + 34'(qtrunc(64'(t_val) * 64'(oc_ff))));
   assign scr_col  = (t_row == t_col) ? row_res : sc_ff;
   assign col_res  = sat32(34'(scr_col) + 34'(qtrunc(64'(t_val) * 64'(or_ff))));

   always_ff @(posedge clock) begin
      if (copy_wr_ff) scr_mem[copy_ix_ff] <= vv_ff;
      if (st_ff == ST_DIAG_WR) begin
         scr_mem[i_ix] <= diag_res;
         old_mem[i_ix] <= ov_ff;
      end
      if (st_ff == ST_TRI_COL) begin
         if (t_row != t_col) begin
            scr_mem[DW'(t_row)] <= row_res;
            scr_mem[DW'(t_col)] <= col_res;
         end else scr_mem[DW'(t_row)] <= col_res;
      end
   end

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> i_ff < n_ff) else $error("emit row out of range");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> st_ff == ST_IDLE) else $error("pop while busy");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.out_last) |=> st_ff == ST_EMIT_RD)
      else $error("last sequencing");
endmodule

FILE: sv/spf_front.sv
// Front part: config registers and item intake into the queue.
// Depends on spf_pkg.
module spf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  spf_pkg::req_type  req_item,
   output logic              busy,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic              q_full,
   output logic              q_push,
   output spf_pkg::req_type  q_item,
   output logic [6:0]        dim_reg,
   output logic [8:0]        count_reg,
   output logic [4:0]        spins_reg,
   output logic [3:0]        desire_reg
);
   import spf_pkg::*;
   logic [6:0] dim_ff; logic [8:0] cnt_ff; logic [4:0] spn_ff; logic [3:0] des_ff;

   assign busy      = q_full;
   assign q_push    = start && !q_full && (req_item.op != OP_NONE);
   assign q_item    = req_item;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 7'd64; cnt_ff <= '0; spn_ff <= 5'd8; des_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DIM:    dim_ff <= csr_data[6:0];
            CSR_COUNT:  cnt_ff <= csr_data[8:0];
            CSR_SPINS:  spn_ff <= csr_data[4:0];
            CSR_DESIRE: des_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end
   assign dim_reg = dim_ff; assign count_reg = cnt_ff;
   assign spins_reg = spn_ff; assign desire_reg = des_ff;
endmodule

FILE: sv/spin_projection_filter.sv
// Top level of the spin projection filter: front, queue, filter engine.
// Depends on spf_pkg, spf_front, spf_queue, spf_engine.
//
// channel   ports                          handshake
// req       start, busy, req_item          start && !busy
// rsp       rsp_strobe, rsp_item           strobe, no backpressure
// csr       csr_valid/ready/index/data     valid && ready
//
// Loads are popped only while the engine is idle. A last-marked vector element
// runs the filter: pop, copy, per pass (the desired spin is skipped) diagonal
// then triples, emit. A triple out of range is skipped without a row or column
// update. Queue is 4 items; busy when full.
// Results are strobed for one cycle and cannot be held off.
// Reset is synchronous; stores are undefined until written.
module spin_projection_filter #(
   parameter int unsigned MAX_DIM     = 64,
   parameter int unsigned MAX_OFFDIAG = 256,
   parameter int unsigned SPIN_LIMIT  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  spf_pkg::req_type  req_item,
   output logic              busy,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   output logic              rsp_strobe,
   output spf_pkg::rsp_type  rsp_item
);
   import spf_pkg::*;
   logic q_full, q_push, q_pop, q_ne;
   req_type q_in, q_out;
   logic [6:0] dim_reg; logic [8:0] count_reg; logic [4:0] spins_reg;
   logic [3:0] desire_reg;

   spf_front u_front (.clock, .reset, .start, .req_item, .busy,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .q_full, .q_push,
      .q_item(q_in), .dim_reg, .count_reg, .spins_reg, .desire_reg);

   spf_queue #(.DEPTH(4)) u_queue (.clock, .reset, .push(q_push),
      .push_item(q_in), .full(q_full), .pop(q_pop), .pop_item(q_out),
      .not_empty(q_ne));

   spf_engine #(.MAX_DIM(MAX_DIM), .MAX_OFFDIAG(MAX_OFFDIAG),
      .SPIN_LIMIT(SPIN_LIMIT)) u_engine (.clock, .reset, .item_valid(q_ne),
      .item(q_out), .item_pop(q_pop), .dim_reg, .count_reg,
      .spins_reg, .desire_reg, .rsp_strobe, .rsp_item);
endmodule

FILE: test/testbench.sv
// Self-checking testbench for spin_projection_filter: loads the spin matrix and vectors,
// predicts every filtered element in Q16.16 and compares each result item.
// Depends on spf_pkg and the spin_projection_filter RTL.
`timescale 1ns / 1ps

module testbench;
   import spf_pkg::*;

   localparam longint CYCLE_LIMIT = 50000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   logic signed [31:0] diag_q [64];
   logic signed [31:0] vec_q [64];
   logic [5:0]         tri_r [256];
   logic [5:0]         tri_c [256];
   logic signed [31:0] tri_v [256];
   int unsigned dim_cfg, count_cfg, spins_cfg, desired_cfg;
   rsp_type filtered_q [$];
   int      errors = 0;
   longint  cycles = 0;

   spin_projection_filter DUT (
      .clock(clock), .reset(reset), .start(start), .req_item(req_item), .busy(busy),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always #1 clock = ~clock;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> 16);
   endfunction

   task automatic project_vector();
      int n, nt;
      logic signed [31:0] work [64];
      logic signed [31:0] prev [64];
      longint shift;
      rsp_type r;
      n  = dim_cfg > 64 ? 64 : dim_cfg;
      nt = count_cfg > 256 ? 256 : count_cfg;
      work = vec_q;
      for (int s = 0; s < (spins_cfg > 16 ? 16 : spins_cfg); s++) begin
         if (s == desired_cfg) continue;
         shift = longint'(s * (s + 2)) * 16384;
         prev = work;
         for (int i = 0; i < n; i++)
            work[i] = qmul(clamp32(longint'(diag_q[i]) - shift), prev[i]);
         for (int k = 0; k < nt; k++) begin
            if (tri_r[k] < n && tri_c[k] < n) begin
               work[tri_r[k]] = clamp32(longint'(work[tri_r[k]])
                                        + qmul(tri_v[k], prev[tri_c[k]]));
               work[tri_c[k]] = clamp32(longint'(work[tri_c[k]])
                                        + qmul(tri_v[k], prev[tri_r[k]]));
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         r.out_row   = i[5:0];
         r.out_value = work[i];
         r.out_last  = (i == n - 1);
         filtered_q.push_back(r);
      end
   endtask

   task automatic apply_item(req_type it);
      case (op_type'(it.op))
         OP_DIAG: if (it.slot < 64) diag_q[it.slot] = it.value;
         OP_TRIPLE: begin
            tri_r[it.slot] = it.row_index;
            tri_c[it.slot] = it.col_index;
            tri_v[it.slot] = it.value;
         end
         OP_VECTOR: begin
            if (it.slot < 64) vec_q[it.slot] = it.value;
            if (it.last) project_vector();
         end
         default: ;
      endcase
   endtask

   function automatic req_type mk(op_type op, int slot, int row, int col,
                                  logic signed [31:0] value, bit last);
      req_type it;
      it.op = op;
      it.slot = slot[7:0];
      it.row_index = row[5:0];
      it.col_index = col[5:0];
      it.value = value;
      it.last = last;
      return it;
   endfunction

   function automatic logic signed [31:0] rand_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return int'($urandom_range(0, 262143)) - 131072;
   endfunction

   task automatic pause(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(req_type it, bit gaps = 1);
      int r;
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      apply_item(it);
      if (gaps) begin
         r = $urandom_range(0, 99);
         if (r < 65) pause(0);
         else if (r < 95) pause($urandom_range(1, 3));
         else pause($urandom_range(10, 40));
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DIM:    dim_cfg     = data & 32'h7f;
         CSR_COUNT:  count_cfg   = data & 32'h1ff;
         CSR_SPINS:  spins_cfg   = data & 32'h1f;
         CSR_DESIRE: desired_cfg = data & 32'hf;
         default: ;
      endcase
   endtask

   task automatic test_reset_defaults();
      // every row and every triple slot is written before any filter runs
      for (int i = 0; i < 64; i++) send_item(mk(OP_DIAG, i, 0, 0, rand_value(), 0));
      for (int i = 0; i < 256; i++)
         send_item(mk(OP_TRIPLE, i, $urandom_range(0, 63), $urandom_range(0, 63),
                       int'($urandom_range(0, 65535)) - 32768, 0));
      for (int i = 0; i < 64; i++)
         send_item(mk(OP_VECTOR, i, 0, 0, rand_value(), i == 63));
   endtask

   task automatic test_field_extremes();
      write_reg(CSR_DIM, 4);
      write_reg(CSR_COUNT, 4);
      write_reg(CSR_SPINS, 3);
      write_reg(CSR_DESIRE, 1);
      send_item(mk(OP_DIAG, 0, 0, 0, 32'sh7fffffff, 1));
      send_item(mk(OP_DIAG, 1, 0, 0, 32'sh80000000, 0));
      send_item(mk(OP_TRIPLE, 0, 63, 0, 32'sh7fffffff, 1));
      send_item(mk(OP_TRIPLE, 1, 2, 2, 32'sh00018000, 0));
      send_item(mk(OP_TRIPLE, 255, 0, 63, 32'sh80000000, 0));
      send_item(mk(OP_VECTOR, 0, 63, 63, 32'sh80000000, 0));
      send_item(mk(OP_VECTOR, 1, 0, 0, 32'sh7fffffff, 0));
      send_item(mk(OP_VECTOR, 3, 0, 0, 32'sh00010000, 1));
      send_item(mk(OP_NONE, 255, 63, 63, 32'shffffffff, 1));
      send_item(mk(OP_DIAG, 200, 0, 0, 32'sh12345678, 0));
      send_item(mk(OP_VECTOR, 255, 0, 0, 32'sh5555aaaa, 1));
      drain();
      send_item(mk(OP_VECTOR, 70, 0, 0, 0, 1), 0);
   endtask

   task automatic test_register_corners();
      write_reg(CSR_SPINS, 0);
      send_item(mk(OP_VECTOR, 2, 0, 0, rand_value(), 1));
      write_reg(CSR_SPINS, 2);
      write_reg(CSR_DESIRE, 15);
      send_item(mk(OP_VECTOR, 2, 0, 0, rand_value(), 1));
      write_reg(CSR_DIM, 0);
      send_item(mk(OP_VECTOR, 0, 0, 0, rand_value(), 1));
      write_reg(CSR_DIM, 1);
      send_item(mk(OP_VECTOR, 0, 0, 0, rand_value(), 1));
      write_reg(CSR_DIM, 127);
      write_reg(CSR_SPINS, 31);
      write_reg(CSR_DESIRE, 0);
      send_item(mk(OP_VECTOR, 5, 0, 0, rand_value(), 1));
   endtask

   task automatic test_full_triples();
      write_reg(CSR_COUNT, 511);
      write_reg(CSR_SPINS, 3);
      write_reg(CSR_DESIRE, 1);
      send_item(mk(OP_VECTOR, 10, 0, 0, rand_value(), 1));
      write_reg(CSR_COUNT, 256);
      write_reg(CSR_SPINS, 16);
      write_reg(CSR_DESIRE, 7);
      send_item(mk(OP_VECTOR, 11, 0, 0, rand_value(), 1));
   endtask

   task automatic test_random_traffic();
      int sent, r, n;
      sent = 0;
      while (sent < 24) begin
         if (sent % 60 == 0) begin
            write_reg(CSR_DIM, $urandom_range(1, 16));
            write_reg(CSR_COUNT, $urandom_range(0, 32));
            write_reg(CSR_SPINS, $urandom_range(0, 16));
            write_reg(CSR_DESIRE, $urandom_range(0, 15));
         end
         r = $urandom_range(0, 99);
         n = dim_cfg > 64 ? 64 : dim_cfg;
         if (r < 45) begin
            for (int i = 0; i < n; i++)
               send_item(mk(OP_VECTOR, i, $urandom, $urandom, rand_value(), i == n - 1));
            sent += n;
         end else if (r < 60) begin
            send_item(mk(OP_DIAG, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                  : $urandom_range(0, 63), $urandom, $urandom,
                         rand_value(), $urandom_range(0, 1)));
            sent++;
         end else if (r < 75) begin
            send_item(mk(OP_TRIPLE, $urandom_range(0, 255), $urandom_range(0, 63),
                         $urandom_range(0, 63), rand_value(), $urandom_range(0, 1)));
            sent++;
         end else if (r < 95) begin
            send_item(mk(OP_VECTOR, $urandom_range(0, 255), $urandom, $urandom,
                         rand_value(), $urandom_range(0, 7) == 0));
            sent++;
         end else begin
            send_item(mk(OP_NONE, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 1)));
         end
         if (r % 17 == 0) drain();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else if (!reset && rsp_strobe) begin
         if (filtered_q.size() == 0) begin
            $error("unexpected result item row %0d", rsp_item.out_row);
            errors++;
         end else begin
            want = filtered_q.pop_front();
            if (rsp_item.out_row !== want.out_row) begin
               $error("out_row expected %0d actual %0d", want.out_row, rsp_item.out_row);
               errors++;
            end
            if (rsp_item.out_value !== want.out_value) begin
               $error("out_value expected %0d actual %0d", want.out_value,
                      rsp_item.out_value);
               errors++;
            end
            if (rsp_item.out_last !== want.out_last) begin
               $error("out_last expected %0d actual %0d", want.out_last,
                      rsp_item.out_last);
               errors++;
            end
         end
      end
   end

   initial begin
      dim_cfg = 64;
      count_cfg = 0;
      spins_cfg = 8;
      desired_cfg = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_register_corners();
      test_full_triples();
      test_random_traffic();
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
